// ----- hw/rtl/ecal_pkg.sv -----
`timescale 1ns / 1ps

package ecal_pkg;

  // Number of register stages from the input to the output register.
  localparam int unsigned PipeDepth = 6;

  // Seconds to days: the count is shifted right by seven, because 86400 is
  // 128 * 675, and then divided by 675 through an exact reciprocal.
  localparam int unsigned DayShift = 7;
  localparam logic [9:0]  DayDiv   = 10'd675;
  localparam logic [25:0] DayRecip = 26'd50903317;   // ceil(2^35 / 675)
  localparam int unsigned DayRecipShift = 35;

  // Days to four-year blocks of 1461 days.
  localparam logic [10:0] BlockDays  = 11'd1461;
  localparam logic [15:0] BlockRecip = 16'd45934;    // ceil(2^26 / 1461)
  localparam int unsigned BlockRecipShift = 26;

  // Year boundaries inside a block: common, common, leap, common.
  localparam logic [10:0] Year1Start = 11'd365;
  localparam logic [10:0] Year2Start = 11'd730;
  localparam logic [10:0] Year3Start = 11'd1096;

  localparam logic [11:0] YearBase = 12'd1970;
  localparam logic [1:0]  LeapYearInBlock = 2'd2;

  // Seconds of the day to hours.
  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [16:0] HourRecip  = 17'd74566;    // ceil(2^28 / 3600)
  localparam int unsigned HourRecipShift = 28;

  // Seconds of the hour to minutes.
  localparam logic [5:0]  SecPerMinute = 6'd60;
  localparam logic [12:0] MinRecip     = 13'd4370;   // ceil(2^18 / 60)
  localparam int unsigned MinRecipShift = 18;

  localparam int unsigned Months = 12;

  typedef logic [8:0] yday_t;

  // Cumulative day count at the start of each month in a common year.
  localparam yday_t MonthStart [Months+1] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // First day of month idx (zero based), one later from March in a leap year.
  function automatic yday_t month_first_day(input logic [3:0] idx, input logic leap);
    yday_t base;
    base = MonthStart[idx];
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ----- hw/rtl/epoch_seconds_to_calendar_top.sv -----
`timescale 1ns / 1ps
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into a
// calendar year, month, day of month, hour, minute and second. Every year
// divisible by four counts as a leap year, so dates are exact up to 2099.
// Input channel: in_valid_i with epoch_seconds_i; a transfer takes place
// at a rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with the six result fields; a transfer takes
// place where out_valid_o is high and out_stall_i is low.
// There are six register stages. The first captures the input at the edge
// of its transfer, and the last is the output register. Throughput is one
// transfer per cycle while the receiver does not stall, as every stage
// holds at most one constant multiplication. When the receiver stalls a
// valid result, the whole pipeline holds and in_stall_o is raised in the
// same cycle, so the result stays stable and nothing is dropped or
// repeated; empty stages are not squeezed out.
// Reset clears all valid bits; the data registers carry no reset.
module epoch_seconds_to_calendar_top import ecal_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic [PipeDepth-1:0] valid_q;
  logic [PipeDepth-1:0] valid_d;
  logic                 advance;
  logic [15:0]          days;
  logic [16:0]          sod;

  // The pipeline moves unless a finished result is waiting on the receiver.
  assign advance    = !(valid_q[PipeDepth-1] && out_stall_i);
  assign in_stall_o = !advance;

  assign valid_d = advance ? {valid_q[PipeDepth-2:0], in_valid_i} : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Two stages split the count into whole days and seconds of the day.
  ecal_day_split u_day_split (
    .clk_i          (clk_i),
    .en_i           (advance),
    .epoch_seconds_i(epoch_seconds_i),
    .days_o         (days),
    .sod_o          (sod)
  );

  // Four stages each turn the day count into a date and the seconds of
  // the day into a time; both paths end in the output register.
  ecal_date u_date (
    .clk_i         (clk_i),
    .en_i          (advance),
    .days_i        (days),
    .year_o        (year_o),
    .month_o       (month_o),
    .day_of_month_o(day_of_month_o)
  );

  ecal_time u_time (
    .clk_i   (clk_i),
    .en_i    (advance),
    .sod_i   (sod),
    .hour_o  (hour_o),
    .minute_o(minute_o),
    .second_o(second_o)
  );

  assign out_valid_o = valid_q[PipeDepth-1];

endmodule

// ----- hw/rtl/ecal_day_split.sv -----
`timescale 1ns / 1ps

module ecal_day_split import ecal_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] epoch_seconds_i,
  output logic [15:0] days_o,
  output logic [16:0] sod_o
);

  logic [50:0] day_prod;
  logic [31:0] sec_q;
  logic [15:0] day_q;
  logic [25:0] day_back;
  logic [24:0] day_rem;
  logic [15:0] days_q;
  logic [16:0] sod_q;

  // First stage: day number by reciprocal multiplication.
  assign day_prod = 51'(epoch_seconds_i[31:DayShift]) * 51'(DayRecip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sec_q <= epoch_seconds_i;
      day_q <= day_prod[DayRecipShift +: 16];
    end
  end

  // Second stage: the remainder in units of 128 seconds, below 675.
  assign day_back = 26'(day_q) * 26'(DayDiv);
  assign day_rem  = sec_q[31:DayShift] - day_back[24:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days_q <= day_q;
      sod_q  <= {day_rem[9:0], sec_q[DayShift-1:0]};
    end
  end

  assign days_o = days_q;
  assign sod_o  = sod_q;

endmodule

// ----- hw/rtl/ecal_date.sv -----
`timescale 1ns / 1ps

module ecal_date import ecal_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] days_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o
);

  logic [31:0] blk_prod;
  logic [15:0] d1_days_q;
  logic [5:0]  d1_blk_q;
  logic [16:0] blk_back;
  logic [15:0] dib_full;
  logic [10:0] d2_dib_q;
  logic [5:0]  d2_blk_q;
  logic [1:0]  yib_d;
  logic [10:0] yoff_d;
  logic [10:0] yday_full;
  logic [1:0]  d3_yib_q;
  yday_t       d3_yday_q;
  logic [5:0]  d3_blk_q;
  logic        leap;
  logic [3:0]  month_d;
  yday_t       lo_d;
  yday_t       mday_full;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  mday_q;

  // Four-year block number.
  assign blk_prod = 32'(days_i) * 32'(BlockRecip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_days_q <= days_i;
      d1_blk_q  <= blk_prod[BlockRecipShift +: 6];
    end
  end

  // Day within the block.
  assign blk_back = 17'(d1_blk_q) * 17'(BlockDays);
  assign dib_full = d1_days_q - blk_back[15:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_dib_q <= dib_full[10:0];
      d2_blk_q <= d1_blk_q;
    end
  end

  // Year within the block and day of the year.
  always_comb begin
    yib_d  = 2'd0;
    yoff_d = '0;
    if (d2_dib_q >= Year3Start) begin
      yib_d  = 2'd3;
      yoff_d = Year3Start;
    end else if (d2_dib_q >= Year2Start) begin
      yib_d  = 2'd2;
      yoff_d = Year2Start;
    end else if (d2_dib_q >= Year1Start) begin
      yib_d  = 2'd1;
      yoff_d = Year1Start;
    end
  end

  assign yday_full = d2_dib_q - yoff_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d3_yib_q  <= yib_d;
      d3_yday_q <= yday_full[8:0];
      d3_blk_q  <= d2_blk_q;
    end
  end

  // Calendar year, month and day of month.
  assign leap = (d3_yib_q == LeapYearInBlock);

  always_comb begin
    month_d = 4'd1;
    lo_d    = '0;
    for (int i = 1; i < Months; i++) begin
      if (d3_yday_q >= month_first_day(4'(i), leap)) begin
        month_d = 4'(i + 1);
        lo_d    = month_first_day(4'(i), leap);
      end
    end
  end

  assign mday_full = d3_yday_q - lo_d + 9'd1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      year_q  <= YearBase + {4'd0, d3_blk_q, 2'b00} + {10'd0, d3_yib_q};
      month_q <= month_d;
      mday_q  <= mday_full[4:0];
    end
  end

  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = mday_q;

endmodule

// ----- hw/rtl/ecal_time.sv -----
`timescale 1ns / 1ps

module ecal_time import ecal_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] sod_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic [33:0] hour_prod;
  logic [16:0] t1_sod_q;
  logic [4:0]  t1_hour_q;
  logic [16:0] hour_back;
  logic [16:0] soh_full;
  logic [11:0] t2_soh_q;
  logic [4:0]  t2_hour_q;
  logic [24:0] min_prod;
  logic [11:0] t3_soh_q;
  logic [4:0]  t3_hour_q;
  logic [5:0]  t3_min_q;
  logic [11:0] min_back;
  logic [11:0] sec_full;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  assign hour_prod = 34'(sod_i) * 34'(HourRecip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_sod_q  <= sod_i;
      t1_hour_q <= hour_prod[HourRecipShift +: 5];
    end
  end

  assign hour_back = 17'(t1_hour_q) * 17'(SecPerHour);
  assign soh_full  = t1_sod_q - hour_back;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_soh_q  <= soh_full[11:0];
      t2_hour_q <= t1_hour_q;
    end
  end

  assign min_prod = 25'(t2_soh_q) * 25'(MinRecip);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3_soh_q  <= t2_soh_q;
      t3_hour_q <= t2_hour_q;
      t3_min_q  <= min_prod[MinRecipShift +: 6];
    end
  end

  assign min_back = 12'(t3_min_q) * 12'(SecPerMinute);
  assign sec_full = t3_soh_q - min_back;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hour_q   <= t3_hour_q;
      minute_q <= t3_min_q;
      second_q <= sec_full[5:0];
    end
  end

  assign hour_o   = hour_q;
  assign minute_o = minute_q;
  assign second_o = second_q;

endmodule

// ----- hw/rtl/ecal_checker.sv -----
`timescale 1ns / 1ps

module ecal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] year_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_of_month_o,
  input logic [4:0]  hour_o,
  input logic [5:0]  minute_o,
  input logic [5:0]  second_o
);

  // A stalled result stays valid, and its date and seconds stay put, until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(year_o) && $stable(month_o)
      && $stable(day_of_month_o) && $stable(second_o))
    else $error("stalled result changed");

  // The input side is only held back by a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_o >= 4'd1 && month_o <= 4'd12 && day_of_month_o != 5'd0
      && year_o >= 12'd1970 && year_o <= 12'd2106)
    else $error("date out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60)
    else $error("time out of range");

endmodule

bind epoch_seconds_to_calendar_top ecal_checker u_ecal_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .year_o        (year_o),
  .month_o       (month_o),
  .day_of_month_o(day_of_month_o),
  .hour_o        (hour_o),
  .minute_o      (minute_o),
  .second_o      (second_o)
);

// ----- tb/tb_epoch_seconds_to_calendar_top.sv -----
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_top;

  // Calendar arithmetic used by the predictor. Every year divisible by four
  // is taken as a leap year, exactly as the block does.
  localparam int unsigned SecsPerMinute = 60;
  localparam int unsigned SecsPerHour   = 3600;
  localparam int unsigned SecsPerDay    = 86400;
  localparam int unsigned SecsPerYear   = 365 * SecsPerDay;
  localparam int unsigned SecsPerLeap   = 366 * SecsPerDay;
  localparam int unsigned SecsPerBlock  = 3 * SecsPerYear + SecsPerLeap;
  localparam int unsigned DaysPerBlock  = 1461;
  localparam int unsigned EpochYear     = 1970;

  // Days before the start of each month in a common year.
  localparam int unsigned CumDays [13] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
  };

  // The output register sits six stages behind the input; the settle time at
  // the end allows comfortably for that.
  localparam int unsigned SettleCycles = 20;

  // Slowest correct run: roughly 1150 transfers, each with the largest drawn
  // idle gap on the sending side, the largest drawn stall on the receiving
  // side and the pipeline depth, plus the long hold-off. The limit is several
  // times that figure.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 300;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_date_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] epoch_seconds_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  // Dates predicted for accepted input transfers, oldest first.
  cal_date_t   pending_dates [$];

  int unsigned error_count   = 0;
  int unsigned seconds_sent  = 0;
  int unsigned dates_checked = 0;
  int unsigned cycle_count   = 0;

  // Idling switches for both sides, and a one-off hold-off request for the
  // receiver, which it counts out in its own process.
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  int unsigned rx_hold_cycles = 0;

  epoch_seconds_to_calendar_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .epoch_seconds_i(epoch_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_of_month_o (day_of_month_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Safety net: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d dates still awaited", $time,
               cycle_count, pending_dates.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Converts a count of seconds since the epoch into a calendar date. The
  // count is split into four-year blocks laid out as common, common, leap,
  // common; the first second of a year belongs to that year.
  function automatic cal_date_t calendar_of(input logic [31:0] secs);
    int unsigned blocks;
    int unsigned rem;
    int unsigned yr;
    int unsigned yday;
    int unsigned lo;
    int unsigned hi;
    bit          leap;
    bit          found;
    cal_date_t   d;
    blocks = secs / SecsPerBlock;
    rem    = secs - blocks * SecsPerBlock;
    yr     = blocks * 4;
    if (rem >= SecsPerYear) begin
      yr++;
      rem -= SecsPerYear;
      if (rem >= SecsPerYear) begin
        yr++;
        rem -= SecsPerYear;
        if (rem >= SecsPerLeap) begin
          yr++;
          rem -= SecsPerLeap;
        end
      end
    end
    yday  = rem / SecsPerDay;
    rem   = rem - yday * SecsPerDay;
    yr    = yr + EpochYear;
    leap  = (yr % 4) == 0;
    d.month = 4'd1;
    d.mday  = 5'd1;
    found   = 1'b0;
    for (int m = 0; m < 12; m++) begin
      lo = CumDays[m] + ((leap && m >= 2) ? 1 : 0);
      hi = CumDays[m + 1] + ((leap && m + 1 >= 2) ? 1 : 0);
      if (!found && yday >= lo && yday < hi) begin
        d.month = 4'(m + 1);
        d.mday  = 5'(yday - lo + 1);
        found   = 1'b1;
      end
    end
    d.year   = 12'(yr);
    d.hour   = 5'(rem / SecsPerHour);
    rem      = rem % SecsPerHour;
    d.minute = 6'(rem / SecsPerMinute);
    d.second = 6'(rem % SecsPerMinute);
    return d;
  endfunction

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Prediction and checking both sample at the rising edge. An input
  // transfer pushes its predicted date; an output transfer is compared with
  // the oldest prediction, field by field.
  always @(posedge clk_i) begin : check_dates
    cal_date_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_dates.push_back(calendar_of(epoch_seconds_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_dates.size() == 0) begin
          $display("%0t: unexpected date %0d-%0d-%0d %0d:%0d:%0d, expected none", $time,
                   year_o, month_o, day_of_month_o, hour_o, minute_o, second_o);
          error_count++;
        end else begin
          want = pending_dates.pop_front();
          report_field("year", want.year, year_o);
          report_field("month", want.month, month_o);
          report_field("day_of_month", want.mday, day_of_month_o);
          report_field("hour", want.hour, hour_o);
          report_field("minute", want.minute, minute_o);
          report_field("second", want.second, second_o);
          dates_checked++;
        end
      end
    end
  end

  // Receiver: before each output transfer it stalls for a drawn number of
  // cycles, or for the long hold-off when one has been requested, and then
  // accepts until the transfer has taken place.
  initial begin : receiver
    int unsigned wait_cycles;
    @(posedge rst_ni);
    forever begin
      wait_cycles = rx_idle_en ? $urandom_range(0, 18) : 0;
      if (rx_hold_cycles > 0) begin
        wait_cycles    = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      @(negedge clk_i);
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Offers one count of seconds after a drawn idle gap and returns just after
  // the rising edge at which the transfer took place. Valid stays high when
  // the next item follows without a gap.
  task automatic send_seconds(input logic [31:0] secs);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 18) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (in_stall_o);
    seconds_sent++;
  endtask

  // Stops offering and waits until every predicted date has been checked.
  task automatic drain_dates();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  // A count close to the start of a randomly chosen month, or a day inside
  // it, so that the year, month and day carries are exercised often.
  function automatic logic [31:0] near_boundary();
    int unsigned blk;
    int unsigned yr_in_block;
    int unsigned m;
    int unsigned days;
    longint      secs;
    blk         = $urandom_range(0, 34);
    yr_in_block = $urandom_range(0, 3);
    m           = $urandom_range(0, 11);
    days = blk * DaysPerBlock + CumDays[m];
    if (yr_in_block > 0) days += 365;
    if (yr_in_block > 1) days += 365;
    if (yr_in_block > 2) days += 366;
    if (yr_in_block == 2 && m >= 2) days += 1;
    if ($urandom_range(0, 3) == 0) days += $urandom_range(0, 27);
    secs = longint'(days) * SecsPerDay + longint'($urandom_range(0, 6)) - 3;
    return secs[31:0];
  endfunction

  // Extremes of the input, every carry of the time of day, the first and
  // last second of each kind of year, leap day, the year 2100 which is
  // treated as leap, and the largest count.
  task automatic test_directed();
    logic [31:0] points [$];
    points = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd63071999, 32'd63072000,
      32'd68169600, 32'd68255999, 32'd68256000, 32'd94694399, 32'd94694400,
      32'd126230399, 32'd126230400, 32'd946684800, 32'h8000_0000,
      32'd4107542400, 32'd4107628800, 32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    foreach (points[i]) send_seconds(points[i]);
    drain_dates();
  endtask

  // Counts drawn over the full 32-bit range, so that every input bit takes
  // both values many times.
  task automatic test_random_uniform(input int unsigned count);
    repeat (count) send_seconds($urandom());
    drain_dates();
  endtask

  task automatic test_random_boundaries(input int unsigned count);
    repeat (count) send_seconds(near_boundary());
    drain_dates();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering without gaps, so the pipeline fills and the input stalls.
  task automatic test_backpressure(input int unsigned count);
    tx_idle_en     = 1'b0;
    rx_hold_cycles = LongHold;
    repeat (count) send_seconds($urandom_range(0, 1) ? $urandom() : near_boundary());
    drain_dates();
    tx_idle_en = 1'b1;
  endtask

  // Both sides at full rate: one transfer per cycle with no idling at all.
  task automatic test_streaming(input int unsigned count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_seconds($urandom_range(0, 1) ? $urandom() : near_boundary());
    drain_dates();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_uniform(450);
    test_random_boundaries(400);
    test_backpressure(100);
    test_streaming(180);

    // Let the pipeline empty completely; anything arriving now is unexpected.
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_dates.size() != 0) begin
      $display("%0t: %0d expected dates never arrived", $time, pending_dates.size());
      error_count += pending_dates.size();
    end

    $display("Converted %0d second counts and checked %0d dates: range extremes,",
             seconds_sent, dates_checked);
    $display("year and month carries, leap days, full-rate streaming and long stalls.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
